// File: hw/rtl/kdlr_pkg.sv
// kdlr_pkg: shared types, constants and register map of the keypad debounce core
// no dependencies; imported by every module of the block
package kdlr_pkg;

    // button count and the walk index derived from it
    localparam int BUTTONS = 16;
    localparam int IDX_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUTTONS - 1);

    // stream widths (fields packed from bit 0, padded to bytes)
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    // config port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
    localparam logic [2:0] REG_HOLD        = 3'd1;
    localparam logic [2:0] REG_REPEAT      = 3'd2;
    localparam logic [2:0] REG_LONG_MASK   = 3'd3;
    localparam logic [2:0] REG_REPEAT_MASK = 3'd4;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [15:0] HOLD_RESET     = 16'd800;
    localparam logic [15:0] REPEAT_RESET   = 16'd100;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [1:0] {
        OP_ATTACH = 2'd0,
        OP_POLL   = 2'd1,
        OP_DETACH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_LONG    = 2'd2,
        EV_REPEAT  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEB,
        S_LONG,
        S_REP,
        S_RSYNC,
        S_FLUSH
    } t_bstate;

    typedef struct packed {
        t_op         op;
        logic [31:0] now;
        logic [15:0] levels;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  idx;
        t_kind       kind;
        logic        flag;
        logic [31:0] stamp;
    } t_event;

    typedef struct packed {
        logic push;
        logic flush;
    } t_evq_ctl;

    typedef struct packed {
        logic [15:0] debounce;
        logic [15:0] hold;
        logic [15:0] rint;
        logic [15:0] long_mask;
        logic [15:0] rep_mask;
    } t_cfg;

endpackage

// File: hw/rtl/kdlr_front.sv
// kdlr_front: accepts input items, drops unused operations, queues commands
// depends on kdlr_pkg
module kdlr_front import kdlr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // operation[1:0], now_time[33:2], raw_levels[49:34], zero pad
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    output logic                 o_cmd_valid,
    output t_cmd                 o_cmd,
    input  logic                 i_cmd_pop
);

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;
    t_op               op;
    logic              push;

    assign op         = t_op'(i_s_tdata[1:0]);
    assign o_s_tready = (r_cnt != QCNT_W'(QDEPTH));
    // unused operation code is consumed without a command
    assign push       = i_s_tvalid && o_s_tready && (op != OP_NONE);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd      = r_q[r_rp];

    always_comb begin
        unique case ({push, i_cmd_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: op, now: i_s_tdata[33:2], levels: i_s_tdata[49:34]};
        end
    end

endmodule

// File: hw/rtl/kdlr_back.sv
// kdlr_back: per-button state and the sequencer that walks buttons on a poll
// depends on kdlr_pkg; feeds events to kdlr_out
module kdlr_back import kdlr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_cmd_valid,
    input  t_cmd     i_cmd,
    output logic     o_cmd_pop,
    input  logic     i_rdy,
    output t_evq_ctl o_ctl,
    output t_event   o_ev
);

    t_bstate          r_state;
    t_bstate          n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_attached;
    logic             n_attached;
    logic [31:0]      r_now;
    logic [15:0]      r_lvl;

    // per-button state
    logic [BUTTONS-1:0] r_raw;
    logic [BUTTONS-1:0] r_stable;
    logic [BUTTONS-1:0] r_ld;
    logic [31:0]        r_rct [BUTTONS];
    logic [31:0]        r_pt  [BUTTONS];
    logic [31:0]        r_nrt [BUTTONS];

    logic        latch;
    logic        attach_we;
    logic        we_raw, we_stable, we_rct, we_pt, we_nrt, we_ld;
    logic        wd_ld;
    logic [31:0] wd_nrt;
    logic        push, flush;
    t_kind       ev_kind;
    logic        ev_flag;

    logic        lvl_bit;
    logic [31:0] rct_n;
    logic [31:0] deb_diff;
    logic        deb_fire;
    logic [31:0] hold_diff;
    logic        long_fire;
    logic [31:0] nrt_cur;
    logic [31:0] due_diff;
    logic        rep_fire;
    logic [31:0] attach_nrt;

    assign lvl_bit   = r_lvl[r_idx];
    assign rct_n     = (lvl_bit != r_raw[r_idx]) ? r_now : r_rct[r_idx];
    assign deb_diff  = r_now - rct_n;
    assign deb_fire  = (lvl_bit != r_stable[r_idx]) && (deb_diff >= {16'd0, i_cfg.debounce});
    assign hold_diff = r_now - r_pt[r_idx];
    assign long_fire = r_stable[r_idx] && i_cfg.long_mask[r_idx] && !r_ld[r_idx]
                       && (hold_diff >= {16'd0, i_cfg.hold});
    assign nrt_cur   = r_nrt[r_idx];
    // due: wrapped difference now - next is not negative
    assign due_diff  = r_now - nrt_cur;
    assign rep_fire  = r_stable[r_idx] && i_cfg.rep_mask[r_idx] && !due_diff[31];
    assign attach_nrt = i_cmd.now + {16'd0, i_cfg.hold};

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_attached = r_attached;
        o_cmd_pop  = 1'b0;
        latch      = 1'b0;
        attach_we  = 1'b0;
        we_raw     = 1'b0;
        we_stable  = 1'b0;
        we_rct     = 1'b0;
        we_pt      = 1'b0;
        we_nrt     = 1'b0;
        we_ld      = 1'b0;
        wd_ld      = 1'b0;
        wd_nrt     = r_now + {16'd0, i_cfg.hold};
        push       = 1'b0;
        flush      = 1'b0;
        ev_kind    = EV_PRESS;
        ev_flag    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_ATTACH: begin
                            attach_we  = 1'b1;
                            n_attached = 1'b1;
                        end
                        OP_DETACH: n_attached = 1'b0;
                        OP_POLL: begin
                            if (r_attached) begin
                                latch   = 1'b1;
                                n_idx   = '0;
                                n_state = S_DEB;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DEB: begin
                if (!deb_fire || i_rdy) begin
                    we_raw  = 1'b1;
                    we_rct  = 1'b1;
                    n_state = S_LONG;
                    if (deb_fire) begin
                        push      = 1'b1;
                        we_stable = 1'b1;
                        if (lvl_bit) begin
                            ev_kind = EV_PRESS;
                            we_pt   = 1'b1;
                            we_nrt  = 1'b1;
                            we_ld   = 1'b1;
                            wd_ld   = 1'b0;
                        end else begin
                            ev_kind = EV_RELEASE;
                            ev_flag = r_ld[r_idx];
                        end
                    end
                end
            end
            S_LONG: begin
                if (!long_fire || i_rdy) begin
                    n_state = S_REP;
                    if (long_fire) begin
                        push    = 1'b1;
                        ev_kind = EV_LONG;
                        ev_flag = 1'b1;
                        we_ld   = 1'b1;
                        wd_ld   = 1'b1;
                    end
                end
            end
            S_REP: begin
                if (rep_fire) begin
                    if (i_rdy) begin
                        push    = 1'b1;
                        ev_kind = EV_REPEAT;
                        we_nrt  = 1'b1;
                        wd_nrt  = nrt_cur + {16'd0, i_cfg.rint};
                        n_state = S_RSYNC;
                    end
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_DEB;
                end
            end
            S_RSYNC: begin
                // schedule fell behind: restart from this poll
                if (!due_diff[31]) begin
                    we_nrt = 1'b1;
                    wd_nrt = r_now + {16'd0, i_cfg.rint};
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_DEB;
                end
            end
            S_FLUSH: begin
                flush = 1'b1;
                if (i_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ctl = '{push: push, flush: flush};
    assign o_ev  = '{idx: 4'(r_idx), kind: ev_kind, flag: ev_flag, stamp: r_now};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_attached <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_attached <= n_attached;
        end
    end

    always_ff @(posedge i_clk) begin
        if (latch) begin
            r_now <= i_cmd.now;
            r_lvl <= i_cmd.levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (attach_we) begin
            for (int b = 0; b < BUTTONS; b++) begin
                r_raw[b]    <= i_cmd.levels[b];
                r_stable[b] <= i_cmd.levels[b];
                r_ld[b]     <= 1'b0;
                r_rct[b]    <= i_cmd.now;
                r_pt[b]     <= i_cmd.now;
                r_nrt[b]    <= attach_nrt;
            end
        end else begin
            if (we_raw)    r_raw[r_idx]    <= lvl_bit;
            if (we_stable) r_stable[r_idx] <= lvl_bit;
            if (we_ld)     r_ld[r_idx]     <= wd_ld;
            if (we_rct)    r_rct[r_idx]    <= rct_n;
            if (we_pt)     r_pt[r_idx]     <= r_now;
            if (we_nrt)    r_nrt[r_idx]    <= wd_nrt;
        end
    end

`ifndef SYNTHESIS
    a_walk_attached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> r_attached)
        else $error("button walk running while detached");
    a_push_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> i_rdy)
        else $error("event pushed while event stage full");
    a_push_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && flush))
        else $error("push and flush together");
    a_rsync_after_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RSYNC) |-> ($past(r_state) == S_REP && $past(push)))
        else $error("resync step without a repeat");
    a_no_pop_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cmd_pop)
        else $error("command taken during a walk");
`endif

endmodule

// File: hw/rtl/kdlr_out.sv
// kdlr_out: one-event holdback that sets tlast on a poll's final event,
// followed by the output register; depends on kdlr_pkg
module kdlr_out import kdlr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_evq_ctl             i_ctl,
    input  t_event               i_ev,
    output logic                 o_rdy,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // button_index[3:0], event_kind[5:4], long_flag[6], event_time[38:7], zero pad
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic                 o_m_tlast
);

    t_event r_pend;
    logic   r_pend_v;
    t_event r_out;
    logic   r_out_v;
    logic   r_out_last;
    logic   out_free;
    logic   load_out;

    assign out_free = !r_out_v || i_m_tready;
    assign o_rdy    = !r_pend_v || out_free;
    // held event moves out when a newer one arrives or the poll ends
    assign load_out = r_pend_v && o_rdy && (i_ctl.push || i_ctl.flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
            if (i_ctl.push && o_rdy) begin
                r_pend_v <= 1'b1;
            end else if (i_ctl.flush && o_rdy) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out      <= r_pend;
            r_out_last <= i_ctl.flush;
        end
        if (i_ctl.push && o_rdy) begin
            r_pend <= i_ev;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {1'b0, r_out.stamp, r_out.flag, r_out.kind, r_out.idx};

endmodule

// File: hw/rtl/keypad_debounce_longpress_repeat_core.sv
// keypad debounce core: attach/poll/detach items in, press/release/long/repeat events out
// an item waits in the two-entry command queue until the sequencer is idle; attach and
// detach update state at the edge that takes them from the queue
// a poll leaves the queue, then each button steps through the debounce, long and repeat
// states (plus a resync state when a repeat fires), a flush state ends it, all subject
// to output stalls; events leave one event late (held to mark tlast) via a one-entry register
// reset: synchronous active low; detached, queue and event stages empty, registers to defaults
module keypad_debounce_longpress_repeat_core import kdlr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // operation[1:0], now_time[33:2], raw_levels[49:34], zero pad
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // event stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // button_index[3:0], event_kind[5:4], long_flag[6], event_time[38:7], zero pad
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // last_event
    output logic                 o_m_tlast,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    t_cfg     r_cfg;
    logic     cfg_wr;
    logic     cmd_valid;
    t_cmd     cmd;
    logic     cmd_pop;
    logic     ev_rdy;
    t_evq_ctl ev_ctl;
    t_event   ev;

    // registers at byte address 4*index, written on the access cycle
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce  <= DEBOUNCE_RESET;
            r_cfg.hold      <= HOLD_RESET;
            r_cfg.rint      <= REPEAT_RESET;
            r_cfg.long_mask <= '0;
            r_cfg.rep_mask  <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_DEBOUNCE:    r_cfg.debounce  <= pwdata[15:0];
                REG_HOLD:        r_cfg.hold      <= pwdata[15:0];
                REG_REPEAT:      r_cfg.rint      <= pwdata[15:0];
                REG_LONG_MASK:   r_cfg.long_mask <= pwdata[15:0];
                REG_REPEAT_MASK: r_cfg.rep_mask  <= pwdata[15:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_DEBOUNCE:    prdata = {16'd0, r_cfg.debounce};
            REG_HOLD:        prdata = {16'd0, r_cfg.hold};
            REG_REPEAT:      prdata = {16'd0, r_cfg.rint};
            REG_LONG_MASK:   prdata = {16'd0, r_cfg.long_mask};
            REG_REPEAT_MASK: prdata = {16'd0, r_cfg.rep_mask};
            default:         prdata = '0;
        endcase
    end

    // front: take items and queue commands
    kdlr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // back: button state and poll walk
    kdlr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_rdy       (ev_rdy),
        .o_ctl       (ev_ctl),
        .o_ev        (ev)
    );

    // event holdback and output register
    kdlr_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ev_ctl),
        .i_ev       (ev),
        .o_rdy      (ev_rdy),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// File: dv/tb_top.sv
// tb_top: self-checking bench for keypad_debounce_longpress_repeat_core
// needs kdlr_pkg and the core rtl; drives the item stream and the register port, checks
// every event against an in-bench model of the debounce, long-press and repeat logic
`timescale 1ns / 100ps

module tb_top import kdlr_pkg::*;;

    // run guards
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    // a poll walks all 16 buttons and two more may sit queued
    localparam int          DRAIN_CYCLES = 250;

    // register indexes past the end of the map, writes to them are dropped
    localparam logic [2:0] REG_SPARE     = 3'd5;
    localparam logic [2:0] REG_TOP_SPARE = 3'd7;

    // one expected or observed event
    typedef struct {
        logic [3:0]  idx;
        t_kind       kind;
        logic        flag;
        logic [31:0] stamp;
        logic        last;
    } t_key_event;

    // clock, reset and dut ports, all known from time zero
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tlast;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [ADDR_W-1:0]    paddr      = '0;
    logic [DATA_W-1:0]    pwdata     = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    // traffic shaping, percent of cycles spent idle or stalled
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int          mismatches  = 0;
    int unsigned cycle_count = 0;

    // stimulus state: the bench's notion of the keypad clock and of the keys held
    logic [31:0] clock_ms   = 32'd0;
    logic [15:0] key_levels = 16'h0000;

    // model copy of the registers and of the per-button state
    t_cfg        model_cfg     = '{DEBOUNCE_RESET, HOLD_RESET, REPEAT_RESET, 16'h0, 16'h0};
    logic        model_attached = 1'b0;
    logic [15:0] raw_seen      = '0;
    logic [15:0] settled       = '0;
    logic [15:0] long_fired    = '0;
    logic [31:0] raw_since     [BUTTONS] = '{default: '0};
    logic [31:0] pressed_at    [BUTTONS] = '{default: '0};
    logic [31:0] repeat_due_at [BUTTONS] = '{default: '0};

    // events predicted but not yet seen on the output stream, oldest first
    t_key_event pending_events[$];

    keypad_debounce_longpress_repeat_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 i_clk = ~i_clk;

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // signed wrap-around test: the deadline has been reached when now - due_at >= 0
    function automatic logic deadline_passed(logic [31:0] now, logic [31:0] due_at);
        logic [31:0] gap;
        gap = now - due_at;
        return !gap[31];
    endfunction

    function automatic string describe_event(t_key_event e);
        return $sformatf("button %0d kind %0d flag %b time %h last %b",
                         e.idx, e.kind, e.flag, e.stamp, e.last);
    endfunction

    // update the model with one accepted item and queue the events it must produce
    function automatic void predict_item(t_op op, logic [31:0] now, logic [15:0] levels);
        t_key_event  found[$];
        logic [31:0] age;
        int          b;
        case (op)
            OP_ATTACH: begin
                // levels taken as already settled, every timer restarts here
                for (b = 0; b < BUTTONS; b++) begin
                    raw_seen[b]      = levels[b];
                    settled[b]       = levels[b];
                    raw_since[b]     = now;
                    pressed_at[b]    = now;
                    repeat_due_at[b] = now + {16'h0, model_cfg.hold};
                    long_fired[b]    = 1'b0;
                end
                model_attached = 1'b1;
            end
            OP_DETACH: model_attached = 1'b0;
            OP_POLL: begin
                if (model_attached) begin
                    for (b = 0; b < BUTTONS; b++) begin
                        // every raw edge restarts the debounce window
                        if (levels[b] != raw_seen[b]) begin
                            raw_seen[b]  = levels[b];
                            raw_since[b] = now;
                        end
                        age = now - raw_since[b];
                        if (raw_seen[b] != settled[b] && age >= {16'h0, model_cfg.debounce}) begin
                            settled[b] = raw_seen[b];
                            if (settled[b]) begin
                                pressed_at[b]    = now;
                                repeat_due_at[b] = now + {16'h0, model_cfg.hold};
                                long_fired[b]    = 1'b0;
                                found.push_back(t_key_event'{4'(b), EV_PRESS, 1'b0, now, 1'b0});
                            end else begin
                                found.push_back(t_key_event'{4'(b), EV_RELEASE, long_fired[b],
                                                             now, 1'b0});
                            end
                        end
                        if (settled[b]) begin
                            age = now - pressed_at[b];
                            if (model_cfg.long_mask[b] && !long_fired[b]
                                    && age >= {16'h0, model_cfg.hold}) begin
                                long_fired[b] = 1'b1;
                                found.push_back(t_key_event'{4'(b), EV_LONG, 1'b1, now, 1'b0});
                            end
                            if (model_cfg.rep_mask[b] && deadline_passed(now, repeat_due_at[b]))
                                    begin
                                repeat_due_at[b] = repeat_due_at[b] + {16'h0, model_cfg.rint};
                                // polls fell behind: restart the schedule from this poll
                                if (deadline_passed(now, repeat_due_at[b]))
                                    repeat_due_at[b] = now + {16'h0, model_cfg.rint};
                                found.push_back(t_key_event'{4'(b), EV_REPEAT, 1'b0, now, 1'b0});
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        // tlast goes on the final event of the poll
        if (found.size() > 0)
            found[found.size() - 1].last = 1'b1;
        foreach (found[k])
            pending_events.push_back(found[k]);
    endfunction

    // event checker: compares every accepted event with the oldest prediction,
    // then registers a new tready drawn from the stall rate
    always @(posedge i_clk) begin : event_monitor
        t_key_event got;
        t_key_event want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.idx   = o_m_tdata[3:0];
            got.kind  = t_kind'(o_m_tdata[5:4]);
            got.flag  = o_m_tdata[6];
            got.stamp = o_m_tdata[38:7];
            got.last  = o_m_tlast;
            if (pending_events.size() == 0) begin
                mismatches++;
                $display("%0t: event with none expected, got %s", $time, describe_event(got));
            end else begin
                want = pending_events.pop_front();
                if (got.idx !== want.idx || got.kind !== want.kind || got.flag !== want.flag
                        || got.stamp !== want.stamp || got.last !== want.last) begin
                    mismatches++;
                    $display("%0t: event mismatch, expected %s, got %s", $time,
                             describe_event(want), describe_event(got));
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one item on the input stream; tvalid stays up afterwards so back-to-back
    // items follow without a gap, the idle loop drops it when a gap is drawn
    task automatic send_item(t_op op, logic [31:0] stamp, logic [15:0] levels);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_W'({levels, stamp, op});
        do @(posedge i_clk); while (!o_s_tready);
        predict_item(op, stamp, levels);
    endtask

    // let every expected event drain, then cover polls that emit nothing
    task automatic settle_block();
        i_s_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // apb write followed by a read back of the same address
    task automatic write_register(logic [2:0] index, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({index, 2'b00});
        // upper half is outside the 16-bit registers, random junk there must not matter
        pwdata  <= {16'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (index)
            REG_DEBOUNCE:    model_cfg.debounce  = value;
            REG_HOLD:        model_cfg.hold      = value;
            REG_REPEAT:      model_cfg.rint      = value;
            REG_LONG_MASK:   model_cfg.long_mask = value;
            REG_REPEAT_MASK: model_cfg.rep_mask  = value;
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (index <= REG_REPEAT_MASK && prdata[15:0] !== value) begin
            mismatches++;
            $display("%0t: register %0d read back, expected %h, got %h", $time, index, value,
                     prdata[15:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_timing(logic [15:0] debounce, logic [15:0] hold, logic [15:0] rint,
                              logic [15:0] long_mask, logic [15:0] rep_mask);
        settle_block();
        write_register(REG_DEBOUNCE, debounce);
        write_register(REG_HOLD, hold);
        write_register(REG_REPEAT, rint);
        write_register(REG_LONG_MASK, long_mask);
        write_register(REG_REPEAT_MASK, rep_mask);
    endtask

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // writes past the register map are dropped, then the reset timing is exercised:
    // 30 ms debounce boundary, a glitch shorter than the window, a clean release
    task automatic test_defaults_and_spare_regs();
        write_register(REG_SPARE, 16'($urandom()));
        write_register(REG_TOP_SPARE, 16'($urandom()));
        send_item(OP_ATTACH, 32'd1000, 16'h0000);
        send_item(OP_POLL,   32'd1010, 16'h8001);
        send_item(OP_POLL,   32'd1039, 16'h8001);
        send_item(OP_POLL,   32'd1040, 16'h8001);
        send_item(OP_POLL,   32'd1045, 16'h8000);
        send_item(OP_POLL,   32'd1050, 16'h8001);
        send_item(OP_POLL,   32'd1100, 16'h0000);
        send_item(OP_POLL,   32'd1130, 16'h0000);
    endtask

    // unused opcode, polls while detached, attach capturing held keys silently
    task automatic test_idle_operations();
        send_item(OP_NONE,   32'hFFFF_0000, 16'hFFFF);
        send_item(OP_DETACH, 32'd1210, 16'hFFFF);
        send_item(OP_POLL,   32'd1300, 16'hFFFF);
        send_item(OP_ATTACH, 32'd1310, 16'h00FF);
    endtask

    // all timing at zero and every key enabled: press, long and repeat for all
    // sixteen buttons in a single poll, across the 32-bit wrap
    task automatic test_extreme_timing();
        set_timing(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_item(OP_ATTACH, 32'hFFFF_FFFF, 16'h0000);
        send_item(OP_POLL,   32'h0000_0000, 16'hFFFF);
        send_item(OP_POLL,   32'h0000_0000, 16'hFFFF);
        send_item(OP_POLL,   32'h0000_0001, 16'h0000);
    endtask

    // all timing at its maximum, the debounce boundary hit exactly, hold and repeat one past
    task automatic test_long_timing();
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hA5A5, 16'h5AF0);
        send_item(OP_ATTACH, 32'h7FFF_0000, 16'h0000);
        send_item(OP_POLL,   32'h7FFF_0001, 16'hFFFF);
        send_item(OP_POLL,   32'h8000_0000, 16'hFFFF);
        send_item(OP_POLL,   32'h8000_0001, 16'hFFFF);
        send_item(OP_POLL,   32'h8001_0000, 16'hFFFF);
    endtask

    // keys held at attach start repeating after the hold delay, and a late poll
    // makes the repeat schedule resync to the poll time
    task automatic test_repeat_catch_up();
        set_timing(16'd5, 16'd50, 16'd20, 16'h00F0, 16'h0F0F);
        send_item(OP_ATTACH, 32'h8000_0000, 16'h0101);
        send_item(OP_POLL,   32'h8000_0032, 16'h0111);
        send_item(OP_POLL,   32'h8000_0046, 16'h0111);
        send_item(OP_POLL,   32'h8000_012C, 16'h0111);
    endtask

    // ------------------------------------------------------------------
    // random traffic: mostly attached poll streams with keys toggling now and
    // then and small time steps, mixed with attach/detach, unused ops and jumps
    // ------------------------------------------------------------------
    task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
        int          counted;
        int          roll;
        int          b;
        t_op         op;
        logic [31:0] advance;
        logic [15:0] flips;
        set_timing(16'($urandom_range(20)), 16'($urandom_range(120)), 16'($urandom_range(40)),
                   16'($urandom()), 16'($urandom()));
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        counted = 0;
        while (counted < n_items) begin
            roll = $urandom_range(99);
            if (!model_attached)
                op = (roll < 50) ? OP_ATTACH : (roll < 80) ? OP_POLL
                   : (roll < 90) ? OP_DETACH : OP_NONE;
            else
                op = (roll < 3) ? OP_ATTACH : (roll < 6) ? OP_DETACH
                   : (roll < 9) ? OP_NONE : OP_POLL;

            // small steps land on the debounce and hold edges, rare jumps go anywhere
            roll = $urandom_range(99);
            if (roll < 80)
                advance = 32'($urandom_range(15));
            else if (roll < 95)
                advance = 32'($urandom_range(300, 16));
            else
                advance = $urandom();
            clock_ms = clock_ms + advance;

            if ($urandom_range(19) == 0) begin
                key_levels = 16'($urandom());
            end else begin
                flips = '0;
                for (b = 0; b < BUTTONS; b++)
                    if ($urandom_range(11) == 0)
                        flips[b] = 1'b1;
                key_levels = key_levels ^ flips;
            end

            // polls while detached and the unused op do nothing, so they are not counted
            if (op == OP_ATTACH || op == OP_DETACH || (op == OP_POLL && model_attached))
                counted++;
            send_item(op, clock_ms, key_levels);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults_and_spare_regs();
        test_idle_operations();
        test_extreme_timing();
        test_long_timing();
        test_repeat_catch_up();

        // no gaps, sender gaps, receiver stalls, then both
        test_random_traffic(0, 0, 115);
        test_random_traffic(62, 0, 115);
        test_random_traffic(0, 62, 115);
        test_random_traffic(15, 15, 115);

        settle_block();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: keypad_debounce_longpress_repeat_core.f
hw/rtl/kdlr_pkg.sv
hw/rtl/kdlr_front.sv
hw/rtl/kdlr_back.sv
hw/rtl/kdlr_out.sv
hw/rtl/keypad_debounce_longpress_repeat_core.sv
dv/tb_top.sv
